>>> rtl/pmg_pkg.sv
// shared types, constants and arithmetic helpers of the particle-mesh gravity engine
`default_nettype none

package pmg_pkg;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int IDX_W     = 9;
    localparam int EXT_W     = 9;
    localparam int MA_W      = 33;
    localparam int MB_W      = 25;
    localparam int MP_W      = 58;
    localparam int DENS_W    = 10;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_RUN  = 2'd1,
        OP_READ = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUBBLE_GAIN    = 3'd0,
        CFG_TIME_STEP      = 3'd1,
        CFG_GRID_OFFSET    = 3'd2,
        CFG_RELAX_SWEEPS   = 3'd3,
        CFG_STEP_COUNT     = 3'd4,
        CFG_GRAVITY_CONST  = 3'd5,
        CFG_PARTICLE_COUNT = 3'd6,
        CFG_GRID_EXTENT    = 3'd7
    } cfg_idx_t;

    localparam logic RES_RUN  = 1'b0;
    localparam logic RES_READ = 1'b1;

    localparam logic [23:0] RST_HUBBLE_GAIN    = 24'd229376;
    localparam logic [16:0] RST_TIME_STEP      = 17'd6554;
    localparam logic [6:0]  RST_GRID_OFFSET    = 7'd50;
    localparam logic [7:0]  RST_RELAX_SWEEPS   = 8'd20;
    localparam logic [9:0]  RST_STEP_COUNT     = 10'd40;
    localparam logic [23:0] RST_GRAVITY_CONST  = 24'd65536;
    localparam logic [9:0]  RST_PARTICLE_COUNT = 10'd500;
    localparam logic [7:0]  RST_GRID_EXTENT    = 8'd99;

    localparam logic [DENS_W-1:0] DENS_MAX = 10'd1023;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_LD_MX,
        ST_LD_MY,
        ST_LD_WY,
        ST_RD_WAIT,
        ST_RD_OUT,
        ST_STEP,
        ST_CLR,
        ST_DEP_START,
        ST_DEP_RD,
        ST_DEP_CELL,
        ST_DEP_INC,
        ST_SW_START,
        ST_SW_ISSUE,
        ST_SW_ACC,
        ST_SW_WR,
        ST_F_START,
        ST_F_RD,
        ST_F_CELL,
        ST_F_HERE,
        ST_F_RIGHT,
        ST_F_DOWN,
        ST_K_X,
        ST_K_Y,
        ST_D_X,
        ST_D_Y,
        ST_D_W,
        ST_STEP_END,
        ST_DONE
    } state_t;

    // nearest, ties up: add half lsb then floor
    function automatic logic signed [41:0] rnd16(input logic signed [MP_W-1:0] p);
        logic signed [MP_W-1:0] t;
        t = p + 58'sd32768;
        return t[MP_W-1:16];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [43:0] v);
        logic [31:0] r;
        if (v > 44'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -44'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // grid cell of a q16.16 coordinate, floor(pos + 0.5)
    function automatic logic signed [16:0] cell_of(input logic [31:0] pos);
        logic signed [32:0] t;
        t = $signed({pos[31], pos}) + 33'sd32768;
        return t[32:16];
    endfunction

endpackage

`default_nettype wire

>>> rtl/pmg_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module pmg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/pmg_mul.sv
// shared signed multiplier with registered product
`default_nettype none

module pmg_mul (
    input  logic                           clk,
    input  logic signed [pmg_pkg::MA_W-1:0] a,
    input  logic signed [pmg_pkg::MB_W-1:0] b,
    output logic signed [pmg_pkg::MP_W-1:0] p
);

    import pmg_pkg::*;

    always_ff @(posedge clk)
    begin
        p <= MP_W'(a) * MP_W'(b);
    end

endmodule

`default_nettype wire

>>> rtl/particle_mesh_gravity_step.sv
// particle-mesh gravity engine top level: sequencer, datapath and memories
// load writes the positions, then x velocity, then y velocity; read waits for a free output register
// run: per step a density clear, particle deposit, relaxation sweeps and force/kick/drift
//   per particle, all on one shared multiplier
// reset clears all (2**clog2(GRID_SIZE))**2 potential memory entries, one entry a cycle,
//   while no word is accepted; config registers take reset values at once
`default_nettype none

module particle_mesh_gravity_step #(
    parameter int MAX_PARTICLES = 512,
    parameter int GRID_SIZE     = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // particle_index, start_x, start_y, zero pad
    input  logic [1:0]  s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // read_index, pos_x, pos_y, zero pad
    output logic [0:0]  m_axis_tuser,  // result_kind
    input  logic        cfg_we,
    input  logic [pmg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pmg_pkg::CFG_W-1:0]     cfg_data
);

    import pmg_pkg::*;

    localparam int GW   = $clog2(GRID_SIZE);
    localparam int GA_W = 2 * GW;
    localparam int PW   = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int PCW  = $clog2(MAX_PARTICLES + 1);
    localparam logic [EXT_W-1:0] GRID_EXT = EXT_W'(GRID_SIZE);
    localparam logic [PCW-1:0]   PART_MAX = PCW'(MAX_PARTICLES);

    state_t state_reg, state_next;

    logic [23:0] gain_reg, gain_next;
    logic [16:0] dt_reg, dt_next;
    logic [6:0]  off_reg, off_next;
    logic [7:0]  sweeps_reg, sweeps_next;
    logic [9:0]  steps_reg, steps_next;
    logic [23:0] grav_reg, grav_next;
    logic [9:0]  count_reg, count_next;
    logic [7:0]  extent_reg, extent_next;

    logic [GW-1:0]   ix_reg, ix_next, iy_reg, iy_next;
    logic [1:0]      nb_reg, nb_next;
    logic [PCW-1:0]  p_reg, p_next;
    logic [7:0]      sweep_reg, sweep_next;
    logic [9:0]      step_reg, step_next;
    logic [GA_W-1:0] clr_reg, clr_next;

    logic [35:0]   acc_reg, acc_next;
    logic [GW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [31:0]   px_reg, px_next, py_reg, py_next;
    logic [31:0]   vx_reg, vx_next, vy_reg, vy_next;
    logic [32:0]   fx_reg, fx_next, fy_reg, fy_next;
    logic [31:0]   here_reg, here_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic          slot_ok_reg, slot_ok_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg, out_kind_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [31:0]      out_x_reg, out_x_next, out_y_reg, out_y_next;

    // memory ports
    logic            part_we_px, part_we_py, part_we_vx, part_we_vy;
    logic [PW-1:0]   part_waddr, part_raddr;
    logic [31:0]     part_wdata;
    logic [31:0]     pos_x_rd, pos_y_rd, vel_x_rd, vel_y_rd;
    logic            phi_we;
    logic [GA_W-1:0] phi_waddr, phi_raddr;
    logic [31:0]     phi_wdata, phi_rd;
    logic            dens_we;
    logic [GA_W-1:0] dens_waddr, dens_raddr;
    logic [DENS_W-1:0] dens_wdata, dens_rd;

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] prod;

    // derived values
    logic [EXT_W-1:0] ext_c;
    logic [PCW-1:0]   cnt_c;
    logic             ix_last, iy_last, p_last, sweep_last, step_last;
    logic             out_free;
    logic [GW-1:0]    ix_p1, ix_m1, iy_p1, iy_m1, cx_p1, cy_p1;
    logic [GA_W-1:0]  cell_sw, nb_addr;
    logic             nb_ok;
    logic signed [16:0] gx_c, gy_c;
    logic             cell_ok_c;
    logic [GA_W-1:0]  cell_c;
    logic signed [41:0] prod_rnd;
    logic [31:0]      add_base, add_c;
    logic [43:0]      sw_diff;
    logic [31:0]      sw_new, ld_pos_x, ld_pos_y;
    logic [IDX_W-1:0] in_idx;
    logic [PW-1:0]    slot_addr;

    assign in_idx = s_axis_tdata[8:0];

    assign ext_c = ({1'b0, extent_reg} > GRID_EXT) ? GRID_EXT : {1'b0, extent_reg};
    assign cnt_c = (32'(count_reg) > 32'(MAX_PARTICLES)) ? PART_MAX : PCW'(count_reg);

    assign ix_last    = (EXT_W'(ix_reg) + EXT_W'(1)) == ext_c;
    assign iy_last    = (EXT_W'(iy_reg) + EXT_W'(1)) == ext_c;
    assign p_last     = (p_reg + PCW'(1)) == cnt_c;
    assign sweep_last = ({1'b0, sweep_reg} + 9'd1) == {1'b0, sweeps_reg};
    assign step_last  = ({1'b0, step_reg} + 11'd1) == {1'b0, steps_reg};
    assign out_free   = !out_valid_reg || m_axis_tready;

    assign ix_p1 = ix_reg + GW'(1);
    assign ix_m1 = ix_reg - GW'(1);
    assign iy_p1 = iy_reg + GW'(1);
    assign iy_m1 = iy_reg - GW'(1);
    assign cx_p1 = cx_reg + GW'(1);
    assign cy_p1 = cy_reg + GW'(1);
    assign cell_sw = {ix_reg, iy_reg};

    // neighbor order: right, left, up, down in the index space
    always_comb
    begin
        case (nb_reg)
            2'd0:
            begin
                nb_addr = {ix_p1, iy_reg};
                nb_ok   = (EXT_W'(ix_reg) + EXT_W'(1)) < ext_c;
            end
            2'd1:
            begin
                nb_addr = {ix_m1, iy_reg};
                nb_ok   = ix_reg != '0;
            end
            2'd2:
            begin
                nb_addr = {ix_reg, iy_p1};
                nb_ok   = (EXT_W'(iy_reg) + EXT_W'(1)) < ext_c;
            end
            default:
            begin
                nb_addr = {ix_reg, iy_m1};
                nb_ok   = iy_reg != '0;
            end
        endcase
    end

    assign gx_c = cell_of(pos_x_rd);
    assign gy_c = cell_of(pos_y_rd);
    assign cell_ok_c = !gx_c[16] && !gy_c[16]
                     && (gx_c < $signed({8'd0, ext_c})) && (gy_c < $signed({8'd0, ext_c}));
    assign cell_c = {gx_c[GW-1:0], gy_c[GW-1:0]};

    assign prod_rnd = rnd16(prod);
    assign add_c = sat32($signed({{12{add_base[31]}}, add_base})
                         + $signed({{2{prod_rnd[41]}}, prod_rnd}));

    assign sw_diff = {{8{acc_reg[35]}}, acc_reg} - prod[43:0];
    assign sw_new  = sat32($signed({{2{sw_diff[43]}}, sw_diff[43:2]}));

    assign ld_pos_x = sat32($signed({{12{sx_reg[31]}}, sx_reg}) + $signed({21'd0, off_reg, 16'd0}));
    assign ld_pos_y = sat32($signed({{12{sy_reg[31]}}, sy_reg}) + $signed({21'd0, off_reg, 16'd0}));

    assign slot_addr = PW'(idx_reg);

    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {7'd0, out_y_reg, out_x_reg, out_idx_reg};

    always_comb
    begin
        state_next   = state_reg;
        gain_next    = gain_reg;
        dt_next      = dt_reg;
        off_next     = off_reg;
        sweeps_next  = sweeps_reg;
        steps_next   = steps_reg;
        grav_next    = grav_reg;
        count_next   = count_reg;
        extent_next  = extent_reg;
        ix_next      = ix_reg;
        iy_next      = iy_reg;
        nb_next      = nb_reg;
        p_next       = p_reg;
        sweep_next   = sweep_reg;
        step_next    = step_reg;
        clr_next     = clr_reg;
        acc_next     = acc_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        fx_next      = fx_reg;
        fy_next      = fy_reg;
        here_next    = here_reg;
        idx_next     = idx_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        slot_ok_next = slot_ok_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_idx_next   = out_idx_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;

        part_we_px = 1'b0;
        part_we_py = 1'b0;
        part_we_vx = 1'b0;
        part_we_vy = 1'b0;
        part_waddr = p_reg[PW-1:0];
        part_raddr = p_reg[PW-1:0];
        part_wdata = add_c;
        phi_we     = 1'b0;
        phi_waddr  = cell_sw;
        phi_wdata  = sw_new;
        phi_raddr  = cell_sw;
        dens_we    = 1'b0;
        dens_waddr = cell_sw;
        dens_wdata = '0;
        dens_raddr = cell_sw;
        mul_a      = '0;
        mul_b      = '0;
        add_base   = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HUBBLE_GAIN:    gain_next   = cfg_data[23:0];
                CFG_TIME_STEP:      dt_next     = cfg_data[16:0];
                CFG_GRID_OFFSET:    off_next    = cfg_data[6:0];
                CFG_RELAX_SWEEPS:   sweeps_next = cfg_data[7:0];
                CFG_STEP_COUNT:     steps_next  = cfg_data[9:0];
                CFG_GRAVITY_CONST:  grav_next   = cfg_data[23:0];
                CFG_PARTICLE_COUNT: count_next  = cfg_data[9:0];
                CFG_GRID_EXTENT:    extent_next = cfg_data[7:0];
                default:            gain_next   = gain_reg;
            endcase
        end

        case (state_reg)
            ST_INIT:
            begin
                phi_we    = 1'b1;
                phi_waddr = clr_reg;
                phi_wdata = '0;
                clr_next  = clr_reg + GA_W'(1);
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    idx_next     = in_idx;
                    sx_next      = s_axis_tdata[40:9];
                    sy_next      = s_axis_tdata[72:41];
                    slot_ok_next = 32'(in_idx) < 32'(MAX_PARTICLES);
                    case (op_t'(s_axis_tuser))
                        OP_LOAD:
                        begin
                            if (32'(in_idx) < 32'(MAX_PARTICLES))
                            begin
                                state_next = ST_LD_MX;
                            end
                        end
                        OP_RUN:
                        begin
                            step_next  = '0;
                            state_next = (steps_reg == '0) ? ST_DONE : ST_STEP;
                        end
                        OP_READ:
                        begin
                            state_next = ST_RD_WAIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LD_MX:
            begin
                part_waddr = slot_addr;
                part_we_px = 1'b1;
                part_we_py = 1'b1;
                part_wdata = ld_pos_x;
                mul_a      = $signed({sx_reg[31], sx_reg});
                mul_b      = $signed({1'b0, gain_reg});
                state_next = ST_LD_MY;
            end
            ST_LD_MY:
            begin
                part_waddr = slot_addr;
                part_we_vx = 1'b1;
                mul_a      = $signed({sy_reg[31], sy_reg});
                mul_b      = $signed({1'b0, gain_reg});
                state_next = ST_LD_WY;
            end
            ST_LD_WY:
            begin
                part_waddr = slot_addr;
                part_we_vy = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RD_WAIT:
            begin
                part_raddr = slot_addr;
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                part_raddr = slot_addr;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = RES_READ;
                    out_idx_next   = idx_reg;
                    out_x_next     = slot_ok_reg ? pos_x_rd : '0;
                    out_y_next     = slot_ok_reg ? pos_y_rd : '0;
                    state_next     = ST_IDLE;
                end
            end
            ST_STEP:
            begin
                ix_next    = '0;
                iy_next    = '0;
                state_next = (ext_c == '0) ? ST_DEP_START : ST_CLR;
            end
            ST_CLR:
            begin
                dens_we    = 1'b1;
                dens_wdata = '0;
                if (iy_last)
                begin
                    iy_next = '0;
                    if (ix_last)
                    begin
                        state_next = ST_DEP_START;
                    end
                    else
                    begin
                        ix_next = ix_p1;
                    end
                end
                else
                begin
                    iy_next = iy_p1;
                end
            end
            ST_DEP_START:
            begin
                p_next     = '0;
                state_next = (cnt_c == '0) ? ST_SW_START : ST_DEP_RD;
            end
            ST_DEP_RD:
            begin
                state_next = ST_DEP_CELL;
            end
            ST_DEP_CELL:
            begin
                dens_raddr = cell_c;
                cx_next    = gx_c[GW-1:0];
                cy_next    = gy_c[GW-1:0];
                if (cell_ok_c)
                begin
                    state_next = ST_DEP_INC;
                end
                else if (p_last)
                begin
                    state_next = ST_SW_START;
                end
                else
                begin
                    p_next     = p_reg + PCW'(1);
                    state_next = ST_DEP_RD;
                end
            end
            ST_DEP_INC:
            begin
                dens_we    = 1'b1;
                dens_waddr = {cx_reg, cy_reg};
                dens_wdata = (dens_rd < DENS_MAX) ? dens_rd + DENS_W'(1) : dens_rd;
                if (p_last)
                begin
                    state_next = ST_SW_START;
                end
                else
                begin
                    p_next     = p_reg + PCW'(1);
                    state_next = ST_DEP_RD;
                end
            end
            ST_SW_START:
            begin
                ix_next    = '0;
                iy_next    = '0;
                nb_next    = '0;
                sweep_next = '0;
                state_next = (sweeps_reg == '0 || ext_c == '0) ? ST_F_START : ST_SW_ISSUE;
            end
            ST_SW_ISSUE:
            begin
                phi_raddr  = nb_addr;
                state_next = ST_SW_ACC;
            end
            ST_SW_ACC:
            begin
                acc_next = ((nb_reg == 2'd0) ? 36'd0 : acc_reg)
                         + (nb_ok ? {{4{phi_rd[31]}}, phi_rd} : 36'd0);
                mul_a    = $signed({23'd0, dens_rd});
                mul_b    = $signed({1'b0, grav_reg});
                if (nb_reg == 2'd3)
                begin
                    state_next = ST_SW_WR;
                end
                else
                begin
                    nb_next    = nb_reg + 2'd1;
                    state_next = ST_SW_ISSUE;
                end
            end
            ST_SW_WR:
            begin
                phi_we     = 1'b1;
                nb_next    = '0;
                state_next = ST_SW_ISSUE;
                if (iy_last)
                begin
                    iy_next = '0;
                    if (ix_last)
                    begin
                        ix_next = '0;
                        if (sweep_last)
                        begin
                            state_next = ST_F_START;
                        end
                        else
                        begin
                            sweep_next = sweep_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        ix_next = ix_p1;
                    end
                end
                else
                begin
                    iy_next = iy_p1;
                end
            end
            ST_F_START:
            begin
                p_next     = '0;
                state_next = (cnt_c == '0) ? ST_STEP_END : ST_F_RD;
            end
            ST_F_RD:
            begin
                state_next = ST_F_CELL;
            end
            ST_F_CELL:
            begin
                px_next = pos_x_rd;
                py_next = pos_y_rd;
                vx_next = vel_x_rd;
                vy_next = vel_y_rd;
                cx_next = gx_c[GW-1:0];
                cy_next = gy_c[GW-1:0];
                if (cell_ok_c)
                begin
                    phi_raddr  = cell_c;
                    state_next = ST_F_HERE;
                end
                else
                begin
                    fx_next    = '0;
                    fy_next    = '0;
                    state_next = ST_K_X;
                end
            end
            ST_F_HERE:
            begin
                here_next  = phi_rd;
                phi_raddr  = {cx_p1, cy_reg};
                state_next = ST_F_RIGHT;
            end
            ST_F_RIGHT:
            begin
                fx_next = {here_reg[31], here_reg}
                        - (((EXT_W'(cx_reg) + EXT_W'(1)) < ext_c) ? {phi_rd[31], phi_rd} : 33'd0);
                phi_raddr  = {cx_reg, cy_p1};
                state_next = ST_F_DOWN;
            end
            ST_F_DOWN:
            begin
                fy_next = {here_reg[31], here_reg}
                        - (((EXT_W'(cy_reg) + EXT_W'(1)) < ext_c) ? {phi_rd[31], phi_rd} : 33'd0);
                state_next = ST_K_X;
            end
            ST_K_X:
            begin
                mul_a      = $signed(fx_reg);
                mul_b      = $signed({8'd0, dt_reg});
                state_next = ST_K_Y;
            end
            ST_K_Y:
            begin
                add_base   = vx_reg;
                part_we_vx = 1'b1;
                vx_next    = add_c;
                mul_a      = $signed(fy_reg);
                mul_b      = $signed({8'd0, dt_reg});
                state_next = ST_D_X;
            end
            ST_D_X:
            begin
                add_base   = vy_reg;
                part_we_vy = 1'b1;
                vy_next    = add_c;
                mul_a      = $signed({vx_reg[31], vx_reg});
                mul_b      = $signed({8'd0, dt_reg});
                state_next = ST_D_Y;
            end
            ST_D_Y:
            begin
                add_base   = px_reg;
                part_we_px = 1'b1;
                mul_a      = $signed({vy_reg[31], vy_reg});
                mul_b      = $signed({8'd0, dt_reg});
                state_next = ST_D_W;
            end
            ST_D_W:
            begin
                add_base   = py_reg;
                part_we_py = 1'b1;
                if (p_last)
                begin
                    state_next = ST_STEP_END;
                end
                else
                begin
                    p_next     = p_reg + PCW'(1);
                    state_next = ST_F_RD;
                end
            end
            ST_STEP_END:
            begin
                if (step_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next  = step_reg + 10'd1;
                    state_next = ST_STEP;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = RES_RUN;
                    out_idx_next   = '0;
                    out_x_next     = '0;
                    out_y_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            gain_reg      <= RST_HUBBLE_GAIN;
            dt_reg        <= RST_TIME_STEP;
            off_reg       <= RST_GRID_OFFSET;
            sweeps_reg    <= RST_RELAX_SWEEPS;
            steps_reg     <= RST_STEP_COUNT;
            grav_reg      <= RST_GRAVITY_CONST;
            count_reg     <= RST_PARTICLE_COUNT;
            extent_reg    <= RST_GRID_EXTENT;
            ix_reg        <= '0;
            iy_reg        <= '0;
            nb_reg        <= '0;
            p_reg         <= '0;
            sweep_reg     <= '0;
            step_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gain_reg      <= gain_next;
            dt_reg        <= dt_next;
            off_reg       <= off_next;
            sweeps_reg    <= sweeps_next;
            steps_reg     <= steps_next;
            grav_reg      <= grav_next;
            count_reg     <= count_next;
            extent_reg    <= extent_next;
            ix_reg        <= ix_next;
            iy_reg        <= iy_next;
            nb_reg        <= nb_next;
            p_reg         <= p_next;
            sweep_reg     <= sweep_next;
            step_reg      <= step_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        fx_reg       <= fx_next;
        fy_reg       <= fy_next;
        here_reg     <= here_next;
        idx_reg      <= idx_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        slot_ok_reg  <= slot_ok_next;
        out_kind_reg <= out_kind_next;
        out_idx_reg  <= out_idx_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
    end

    pmg_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    pmg_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_pos_x (
        .clk (clk), .we (part_we_px), .waddr (part_waddr),
        .wdata (part_we_py && state_reg == ST_LD_MX ? ld_pos_x : part_wdata),
        .raddr (part_raddr), .rdata (pos_x_rd)
    );

    pmg_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_pos_y (
        .clk (clk), .we (part_we_py), .waddr (part_waddr),
        .wdata (state_reg == ST_LD_MX ? ld_pos_y : part_wdata),
        .raddr (part_raddr), .rdata (pos_y_rd)
    );

    pmg_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_vel_x (
        .clk (clk), .we (part_we_vx), .waddr (part_waddr), .wdata (part_wdata),
        .raddr (part_raddr), .rdata (vel_x_rd)
    );

    pmg_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_vel_y (
        .clk (clk), .we (part_we_vy), .waddr (part_waddr), .wdata (part_wdata),
        .raddr (part_raddr), .rdata (vel_y_rd)
    );

    pmg_ram #(.WIDTH(32), .DEPTH(1 << GA_W)) u_phi (
        .clk (clk), .we (phi_we), .waddr (phi_waddr), .wdata (phi_wdata),
        .raddr (phi_raddr), .rdata (phi_rd)
    );

    pmg_ram #(.WIDTH(DENS_W), .DEPTH(1 << GA_W)) u_dens (
        .clk (clk), .we (dens_we), .waddr (dens_waddr), .wdata (dens_wdata),
        .raddr (dens_raddr), .rdata (dens_rd)
    );

`ifndef SYNTHESIS
    a_init_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |-> !s_axis_tready)
        else $error("word accepted during potential clear");

    a_sweep_after_four: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SW_WR) |-> ($past(state_reg) == ST_SW_ACC && $past(nb_reg) == 2'd3))
        else $error("potential written before all neighbors summed");

    a_particle_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_F_RD || state_reg == ST_DEP_RD) |-> (p_reg < cnt_c))
        else $error("particle counter past active count");

    a_run_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (m_axis_tvalid && m_axis_tuser[0] == RES_RUN))
        else $error("run finish word not presented");
`endif

endmodule

`default_nettype wire

>>> test/particle_mesh_gravity_step_tb.sv
// self-checking testbench for the particle-mesh gravity engine
`default_nettype none

module particle_mesh_gravity_step_tb;
    import pmg_pkg::*;

    localparam int NPART = 512;
    localparam int NGRID = 128;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 20000000;
    localparam int SETTLE = 40;

    typedef struct {
        op_t                op;
        logic [8:0]         slot;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } cmd_t;

    typedef struct {
        logic               kind;
        logic [8:0]         slot;
        logic [31:0]        px;
        logic [31:0]        py;
    } report_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;  // particle_index, start_x, start_y, zero pad
    logic [1:0]  s_axis_tuser;  // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;  // read_index, pos_x, pos_y, zero pad
    logic [0:0]  m_axis_tuser;  // result_kind
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    particle_mesh_gravity_step dut (.*);

    // mirrored engine state
    longint gain, dt, offset, sweeps, steps, gconst, pcount, extent;
    int pos_x[NPART], pos_y[NPART], vel_x[NPART], vel_y[NPART];
    int cell_x[NPART], cell_y[NPART];
    bit cell_ok[NPART];
    int phi[NGRID*NGRID];
    int dens[NGRID*NGRID];

    cmd_t    pending[$];
    report_t awaited[$];
    bit      hold_off;
    bit      no_gaps;
    int      n_fail, n_words, n_runs, n_reads;
    longint  cycles;

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint rnd(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return int'(v);
    endfunction

    function automatic longint phi_get(longint ix, longint iy, longint e);
        if (ix < 0 || iy < 0 || ix >= e || iy >= e)
            return 0;
        return phi[ix*NGRID + iy];
    endfunction

    task automatic advance_step(longint e, int cnt);
        longint gx, gy, sum, fx, fy, vx, vy, here;
        for (int i = 0; i < NGRID*NGRID; i++)
            dens[i] = 0;
        for (int p = 0; p < cnt; p++)
        begin
            gx = (longint'(pos_x[p]) + 32768) >>> 16;
            gy = (longint'(pos_y[p]) + 32768) >>> 16;
            cell_ok[p] = gx >= 0 && gy >= 0 && gx < e && gy < e;
            if (cell_ok[p])
            begin
                cell_x[p] = int'(gx);
                cell_y[p] = int'(gy);
                if (dens[gx*NGRID + gy] < 1023)
                    dens[gx*NGRID + gy]++;
            end
        end
        for (longint s = 0; s < sweeps; s++)
            for (longint ix = 0; ix < e; ix++)
                for (longint iy = 0; iy < e; iy++)
                begin
                    sum = phi_get(ix+1, iy, e) + phi_get(ix-1, iy, e)
                        + phi_get(ix, iy+1, e) + phi_get(ix, iy-1, e);
                    phi[ix*NGRID + iy] = clamp32((sum - gconst * dens[ix*NGRID + iy]) >>> 2);
                end
        for (int p = 0; p < cnt; p++)
        begin
            fx = 0;
            fy = 0;
            if (cell_ok[p])
            begin
                here = phi_get(cell_x[p], cell_y[p], e);
                fx = here - phi_get(cell_x[p] + 1, cell_y[p], e);
                fy = here - phi_get(cell_x[p], cell_y[p] + 1, e);
            end
            vx = clamp32(longint'(vel_x[p]) + rnd(fx * dt));
            vy = clamp32(longint'(vel_y[p]) + rnd(fy * dt));
            vel_x[p] = int'(vx);
            vel_y[p] = int'(vy);
            pos_x[p] = clamp32(longint'(pos_x[p]) + rnd(vx * dt));
            pos_y[p] = clamp32(longint'(pos_y[p]) + rnd(vy * dt));
        end
    endtask

    task automatic apply_word(cmd_t c);
        report_t r;
        longint e;
        case (c.op)
            OP_LOAD:
            begin
                vel_x[c.slot] = clamp32(rnd(gain * longint'(c.sx)));
                vel_y[c.slot] = clamp32(rnd(gain * longint'(c.sy)));
                pos_x[c.slot] = clamp32(longint'(c.sx) + offset * 65536);
                pos_y[c.slot] = clamp32(longint'(c.sy) + offset * 65536);
            end
            OP_RUN:
            begin
                e = extent > NGRID ? NGRID : extent;
                for (longint k = 0; k < steps; k++)
                    advance_step(e, pcount > NPART ? NPART : int'(pcount));
                r = '{RES_RUN, 9'd0, 32'd0, 32'd0};
                awaited.push_back(r);
                n_runs++;
            end
            OP_READ:
            begin
                r = '{RES_READ, c.slot, pos_x[c.slot], pos_y[c.slot]};
                awaited.push_back(r);
                n_reads++;
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver
    int   send_gap;
    cmd_t cur;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_word(cur);
                n_words++;
                send_gap = pick_gap();
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending.size() > 0 && !hold_off)
                begin
                    cur = pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, cur.sy, cur.sx, cur.slot};
                    s_axis_tuser  <= cur.op;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    int      stall;
    report_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected word: kind %0d slot %0d", m_axis_tuser,
                                 m_axis_tdata[8:0]);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (m_axis_tuser[0] !== want.kind || m_axis_tdata[8:0] !== want.slot
                        || m_axis_tdata[40:9] !== want.px
                        || m_axis_tdata[72:41] !== want.py)
                    begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("mismatch: exp kind %0d slot %0d x %h y %h, got %0d %0d %h %h",
                                     want.kind, want.slot, want.px, want.py, m_axis_tuser[0],
                                     m_axis_tdata[8:0], m_axis_tdata[40:9], m_axis_tdata[72:41]);
                    end
                end
                stall = pick_gap();
            end
            if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout, %0d words still expected", awaited.size());
            $display("FAIL particle_mesh_gravity_step");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t i, longint v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= i;
        cfg_data  <= v[CFG_W-1:0];
        case (i)
            CFG_HUBBLE_GAIN:    gain   = v;
            CFG_TIME_STEP:      dt     = v;
            CFG_GRID_OFFSET:    offset = v;
            CFG_RELAX_SWEEPS:   sweeps = v;
            CFG_STEP_COUNT:     steps  = v;
            CFG_GRAVITY_CONST:  gconst = v;
            CFG_PARTICLE_COUNT: pcount = v;
            CFG_GRID_EXTENT:    extent = v;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(longint g, longint t, longint o, longint sw, longint st,
                           longint gc, longint pc, longint ex);
        write_reg(CFG_HUBBLE_GAIN, g);
        write_reg(CFG_TIME_STEP, t);
        write_reg(CFG_GRID_OFFSET, o);
        write_reg(CFG_RELAX_SWEEPS, sw);
        write_reg(CFG_STEP_COUNT, st);
        write_reg(CFG_GRAVITY_CONST, gc);
        write_reg(CFG_PARTICLE_COUNT, pc);
        write_reg(CFG_GRID_EXTENT, ex);
    endtask

    task automatic quiesce();
        do @(negedge clk); while (pending.size() != 0 || s_axis_tvalid);
        do @(negedge clk); while (awaited.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic push(op_t op, int slot, logic [31:0] x, logic [31:0] y);
        cmd_t c;
        c = '{op, slot[8:0], x, y};
        pending.push_back(c);
    endtask

    // start position that lands near or on the active grid
    function automatic logic [31:0] near_grid();
        longint cells;
        cells = longint'($urandom_range(0, extent + 1)) - offset;
        return logic'(0) | 32'(cells * 65536 + $urandom_range(0, 65535) - 32768);
    endfunction

    task automatic random_phase(int n);
        int r;
        int slot;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            slot = $urandom_range(0, NPART - 1);
            if (r < 40)
                push(OP_LOAD, slot, near_grid(), near_grid());
            else if (r < 50)
                push(OP_LOAD, slot, $urandom, $urandom);
            else if (r < 93)
                push(OP_READ, slot, $urandom, $urandom);
            else if (r < 97)
                push(OP_RUN, slot, $urandom, $urandom);
            else
                push(op_t'(OP_UNUSED), slot, $urandom, $urandom);
        end
        push(OP_RUN, 0, 0, 0);
        for (int k = 0; k < 4; k++)
            push(OP_READ, $urandom_range(0, int'(pcount) - 1), 0, 0);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        hold_off  = 1'b0;
        no_gaps   = 1'b0;
        n_fail = 0; n_words = 0; n_runs = 0; n_reads = 0; cycles = 0;
        gain = 229376; dt = 6554; offset = 50; sweeps = 20;
        steps = 40; gconst = 65536; pcount = 500; extent = 99;
        for (int i = 0; i < NGRID*NGRID; i++)
        begin
            phi[i] = 0;
            dens[i] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and saturation on load, every slot written
        set_all(229376, 6554, 50, 2, 1, 65536, 512, 4);
        push(OP_LOAD, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        push(OP_LOAD, 511, 32'h8000_0000, 32'h7FFF_FFFF);
        push(OP_LOAD, 1, 32'hFFFF_FFFF, 32'h0000_0001);
        push(OP_LOAD, 2, 0, 0);
        push(OP_READ, 0, 0, 0);
        push(OP_READ, 511, 0, 0);
        push(OP_READ, 1, 0, 0);
        push(op_t'(OP_UNUSED), 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push(OP_READ, 2, 0, 0);
        quiesce();
        for (int s = 3; s < 511; s++)
            push(OP_LOAD, s, 32'hFFCE_0000 + $urandom_range(0, 4 * 65536),
                 32'hFFCE_0000 + $urandom_range(0, 4 * 65536));
        push(OP_RUN, 0, 0, 0);
        push(OP_READ, 0, 0, 0);
        push(OP_READ, 100, 0, 0);
        // sender waits here until the run has reported
        quiesce();
        hold_off = 1'b1;
        push(OP_READ, 511, 0, 0);
        repeat (50) @(negedge clk);
        hold_off = 1'b0;
        quiesce();

        // register extremes
        set_all(16777215, 65536, 127, 1, 1, 16777215, 8, 128);
        random_phase(10);
        quiesce();
        set_all(0, 0, 0, 255, 1, 0, 4, 2);
        random_phase(10);
        quiesce();
        set_all(65536, 32768, 1, 1, 1023, 65536, 1, 2);
        random_phase(6);
        quiesce();
        set_all(229376, 6554, 0, 1, 0, 65536, 16, 2);
        random_phase(6);
        quiesce();

        // random phases with small grids
        while (n_words < 1900)
        begin
            no_gaps = $urandom_range(0, 3) == 0;
            if ($urandom_range(0, 1))
                set_all($urandom_range(0, 16777215), $urandom_range(0, 65536),
                        $urandom_range(0, 127), $urandom_range(1, 3), $urandom_range(0, 2),
                        $urandom_range(0, 16777215), $urandom_range(1, 16),
                        $urandom_range(2, 6));
            else
                set_all($urandom_range(0, 300000), $urandom_range(0, 8000),
                        $urandom_range(0, 6), $urandom_range(1, 3), $urandom_range(0, 2),
                        $urandom_range(0, 200000), $urandom_range(1, 16),
                        $urandom_range(2, 6));
            random_phase($urandom_range(40, 80));
            quiesce();
        end

        $display("run covered %0d accepted words: %0d simulation runs, %0d particle reads",
                 n_words, n_runs, n_reads);
        $display("register extremes and %0d cycles exercised, %0d mismatches", cycles, n_fail);
        if (n_fail == 0)
            $display("PASS particle_mesh_gravity_step");
        else
            $display("FAIL particle_mesh_gravity_step");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/pmg_pkg.sv
rtl/pmg_ram.sv
rtl/pmg_mul.sv
rtl/particle_mesh_gravity_step.sv
test/particle_mesh_gravity_step_tb.sv
